// ----- hw/rtl/mrrc_pkg.sv -----
// Shared types, constants and state codes for the motor reversal ramp controller.
// No dependencies; every other file of the block imports this package.
package mrrc_pkg;

   localparam int unsigned POT_W        = 10;
   localparam int unsigned SPEED_W      = 8;
   localparam int unsigned STATE_W      = 2;
   localparam int unsigned TIME_W       = 32;
   localparam int unsigned ACCEL_W      = 8;
   localparam int unsigned INTERVAL_W   = 16;
   localparam int unsigned DWELL_W      = 16;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 16;

   localparam int unsigned POT_FULL_SCALE   = 1023;
   localparam int unsigned SPEED_FULL_SCALE = 255;
   localparam int unsigned BLINK_HALF_MS    = 500;

   localparam logic [ACCEL_W-1:0]    RAMP_STEP_RESET   = 8'd5;
   localparam logic [INTERVAL_W-1:0] RAMP_PERIOD_RESET = 16'd20;
   localparam logic [DWELL_W-1:0]    STOP_DWELL_RESET  = 16'd3000;

   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

   // Pot scaling: pot * SPEED_FULL_SCALE / POT_FULL_SCALE done as one multiply by a
   // rounded-up reciprocal, with a shift wide enough that the quotient is exact.
   localparam logic [63:0] SCALE_PROD_MAX =
      64'((2 ** POT_W) - 1) * 64'(SPEED_FULL_SCALE);
   localparam int unsigned SCALE_PROD_W = $clog2(SCALE_PROD_MAX + 64'd1);
   localparam int unsigned SCALE_SHIFT  = SCALE_PROD_W + $clog2(POT_FULL_SCALE + 1);
   localparam logic [63:0] SCALE_RECIP  =
      ((64'd1 << SCALE_SHIFT) + 64'(POT_FULL_SCALE) - 64'd1) / 64'(POT_FULL_SCALE);
   localparam logic [63:0] SCALE_MULT   = SCALE_RECIP * 64'(SPEED_FULL_SCALE);
   localparam int unsigned SCALE_MULT_W = $clog2(SCALE_MULT + 64'd1);
   localparam int unsigned SCALE_FULL_W = POT_W + SCALE_MULT_W;

   localparam int unsigned BLINK_CNT_W = $clog2(BLINK_HALF_MS + 1);

   localparam logic [STATE_W-1:0] ST_STOP     = 2'd0;
   localparam logic [STATE_W-1:0] ST_FWD      = 2'd1;
   localparam logic [STATE_W-1:0] ST_BWD      = 2'd2;
   localparam logic [STATE_W-1:0] ST_STOPPING = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_DWELL  = 2'd2;

   localparam logic [1:0] EN_NONE  = 2'b00;
   localparam logic [1:0] EN_RIGHT = 2'b01;
   localparam logic [1:0] EN_LEFT  = 2'b10;

   typedef struct packed {
      logic               forward_pressed;
      logic               backward_pressed;
      logic               halt_pressed;
      logic [SPEED_W-1:0] pot_goal;
   } mrrc_item_type;

   typedef struct packed {
      logic [ACCEL_W-1:0]    ramp_step;
      logic [INTERVAL_W-1:0] ramp_period;
      logic [DWELL_W-1:0]    stop_dwell;
   } mrrc_cfg_type;

   typedef struct packed {
      logic               right_enable;
      logic               left_enable;
      logic [SPEED_W-1:0] right_duty;
      logic [SPEED_W-1:0] left_duty;
      logic               led_on;
      logic [STATE_W-1:0] motion_state;
      logic [SPEED_W-1:0] speed_now;
      logic [SPEED_W-1:0] speed_goal;
   } mrrc_result_type;

endpackage

// ----- hw/rtl/mrrc_pot_scale.sv -----
// Scales a potentiometer sample to a target speed, saturated at the speed range.
// Depends on mrrc_pkg for the reciprocal constants and widths.
module mrrc_pot_scale (
   input  logic [mrrc_pkg::POT_W-1:0]   pot_level,
   output logic [mrrc_pkg::SPEED_W-1:0] pot_goal
);
   import mrrc_pkg::*;

   logic [SCALE_FULL_W-1:0] product;
   logic [SCALE_FULL_W-1:0] quotient;

   assign product  = SCALE_FULL_W'(pot_level) * SCALE_FULL_W'(SCALE_MULT);
   assign quotient = product >> SCALE_SHIFT;
   assign pot_goal = (quotient > SCALE_FULL_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(quotient);

endmodule

// ----- hw/rtl/mrrc_motion_core.sv -----
// Motion state machine, speed ramp, bridge drive and status lamp of the controller.
// Depends on mrrc_pkg; advances its state by one millisecond tick per step.
module mrrc_motion_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  mrrc_pkg::mrrc_item_type   item,
   input  mrrc_pkg::mrrc_cfg_type    cfg,
   output mrrc_pkg::mrrc_result_type result
);
   import mrrc_pkg::*;

   logic [STATE_W-1:0]     run_state_ff, run_state_in;
   logic [STATE_W-1:0]     req_state_ff, req_state_in;
   logic [SPEED_W-1:0]     cur_speed_ff, cur_speed_in;
   logic [SPEED_W-1:0]     tgt_speed_ff, tgt_speed_in;
   logic                   drive_left_ff, drive_left_in;
   logic [TIME_W-1:0]      time_now_ff, time_now_in;
   logic [TIME_W-1:0]      last_update_ff, last_update_in;
   logic [TIME_W-1:0]      stop_start_ff, stop_start_in;
   logic [1:0]             bridge_en_ff, bridge_en_in;
   logic [SPEED_W-1:0]     duty_right_ff, duty_right_in;
   logic [SPEED_W-1:0]     duty_left_ff, duty_left_in;
   logic [BLINK_CNT_W-1:0] blink_cnt_ff, blink_cnt_in;
   logic                   blink_phase_ff, blink_phase_in;
   logic                   led;

   always_comb begin
      logic [SPEED_W:0] sum;
      logic             update_due;
      logic             dwell_done;

      req_state_in = req_state_ff;
      if (item.forward_pressed) begin
         req_state_in = ST_FWD;
      end
      if (item.backward_pressed) begin
         req_state_in = ST_BWD;
      end
      if (item.halt_pressed) begin
         req_state_in = ST_STOP;
      end

      run_state_in  = run_state_ff;
      cur_speed_in  = cur_speed_ff;
      tgt_speed_in  = tgt_speed_ff;
      drive_left_in = drive_left_ff;
      stop_start_in = stop_start_ff;
      bridge_en_in  = bridge_en_ff;
      duty_right_in = duty_right_ff;
      duty_left_in  = duty_left_ff;
      led           = 1'b0;
      dwell_done    = (time_now_ff - stop_start_ff) >= TIME_W'(cfg.stop_dwell);

      unique case (run_state_ff) inside
         ST_STOP: begin
            led           = 1'b0;
            tgt_speed_in  = '0;
            cur_speed_in  = '0;
            bridge_en_in  = EN_NONE;
            duty_right_in = '0;
            duty_left_in  = '0;
            if ((req_state_in == ST_FWD) || (req_state_in == ST_BWD)) begin
               run_state_in  = req_state_in;
               drive_left_in = (req_state_in == ST_BWD);
               bridge_en_in  = (req_state_in == ST_FWD) ? EN_RIGHT : EN_LEFT;
            end
         end
         ST_FWD, ST_BWD: begin
            led = 1'b1;
            if (req_state_in != run_state_ff) begin
               run_state_in  = ST_STOPPING;
               stop_start_in = time_now_ff;
               tgt_speed_in  = '0;
            end
         end
         ST_STOPPING: begin
            led = blink_phase_ff;
            if ((cur_speed_ff == '0) && dwell_done) begin
               if ((req_state_in == ST_FWD) || (req_state_in == ST_BWD)) begin
                  run_state_in  = req_state_in;
                  drive_left_in = (req_state_in == ST_BWD);
                  bridge_en_in  = (req_state_in == ST_FWD) ? EN_RIGHT : EN_LEFT;
               end else begin
                  run_state_in = ST_STOP;
               end
            end
         end
         default: begin
            led = 1'b0;
         end
      endcase

      update_due     = (time_now_ff - last_update_ff) >= TIME_W'(cfg.ramp_period);
      last_update_in = last_update_ff;
      sum            = {1'b0, cur_speed_in} + {1'b0, cfg.ramp_step};
      if (update_due) begin
         last_update_in = time_now_ff;
         if ((run_state_in == ST_FWD) || (run_state_in == ST_BWD)) begin
            tgt_speed_in = item.pot_goal;
         end
         sum = {1'b0, cur_speed_in} + {1'b0, cfg.ramp_step};
         if (cur_speed_in < tgt_speed_in) begin
            cur_speed_in = (sum > {1'b0, tgt_speed_in}) ? tgt_speed_in : sum[SPEED_W-1:0];
         end else if (cur_speed_in > tgt_speed_in) begin
            cur_speed_in = (cur_speed_in > cfg.ramp_step) ?
                           (cur_speed_in - cfg.ramp_step) : '0;
         end
         if (run_state_in != ST_STOP) begin
            if (drive_left_in) begin
               duty_left_in = cur_speed_in;
            end else begin
               duty_right_in = cur_speed_in;
            end
         end
      end

      time_now_in = time_now_ff + TIME_W'(1);
      if (time_now_ff == '1) begin
         blink_cnt_in   = '0;
         blink_phase_in = 1'b0;
      end else if (blink_cnt_ff == BLINK_CNT_W'(BLINK_HALF_MS - 1)) begin
         blink_cnt_in   = '0;
         blink_phase_in = ~blink_phase_ff;
      end else begin
         blink_cnt_in   = blink_cnt_ff + BLINK_CNT_W'(1);
         blink_phase_in = blink_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_state_ff   <= ST_STOP;
         req_state_ff   <= ST_STOP;
         cur_speed_ff   <= '0;
         tgt_speed_ff   <= '0;
         drive_left_ff  <= 1'b0;
         time_now_ff    <= '0;
         last_update_ff <= '0;
         stop_start_ff  <= '0;
         bridge_en_ff   <= EN_NONE;
         duty_right_ff  <= '0;
         duty_left_ff   <= '0;
         blink_cnt_ff   <= '0;
         blink_phase_ff <= 1'b0;
      end else if (step) begin
         run_state_ff   <= run_state_in;
         req_state_ff   <= req_state_in;
         cur_speed_ff   <= cur_speed_in;
         tgt_speed_ff   <= tgt_speed_in;
         drive_left_ff  <= drive_left_in;
         time_now_ff    <= time_now_in;
         last_update_ff <= last_update_in;
         stop_start_ff  <= stop_start_in;
         bridge_en_ff   <= bridge_en_in;
         duty_right_ff  <= duty_right_in;
         duty_left_ff   <= duty_left_in;
         blink_cnt_ff   <= blink_cnt_in;
         blink_phase_ff <= blink_phase_in;
      end
   end

   always_comb begin
      result.right_enable = bridge_en_in[0];
      result.left_enable  = bridge_en_in[1];
      result.right_duty   = duty_right_in;
      result.left_duty    = duty_left_in;
      result.led_on       = led;
      result.motion_state = run_state_in;
      result.speed_now    = cur_speed_in;
      result.speed_goal   = tgt_speed_in;
   end

endmodule

// ----- hw/rtl/motor_reversal_ramp_controller_unit.sv -----
// Top level of the motor reversal ramp controller: handshakes, input and result registers,
// configuration registers. Depends on mrrc_pkg, mrrc_pot_scale and mrrc_motion_core.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  buttons, pot_level
//   rsp      out        rsp_valid / rsp_ready  enables, duties, lamp, state, speeds
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// An accepted item waits in the input register and moves into the result register when the
// result register is empty or being read; an item is accepted every cycle unless rsp stalls.
// The pot scaling multiply sits before the input register and the state update after it.
// Reset is synchronous and returns the valid flags, the core state and the configuration.
// A stalled result holds the pipe; the input register still takes one item meanwhile.
module motor_reversal_ramp_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_forward_pressed,
   input  logic                              req_backward_pressed,
   input  logic                              req_halt_pressed,
   input  logic [mrrc_pkg::POT_W-1:0]        req_pot_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_right_enable,
   output logic                              rsp_left_enable,
   output logic [mrrc_pkg::SPEED_W-1:0]      rsp_right_duty,
   output logic [mrrc_pkg::SPEED_W-1:0]      rsp_left_duty,
   output logic                              rsp_led_on,
   output logic [mrrc_pkg::STATE_W-1:0]      rsp_motion_state,
   output logic [mrrc_pkg::SPEED_W-1:0]      rsp_speed_now,
   output logic [mrrc_pkg::SPEED_W-1:0]      rsp_speed_goal,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mrrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mrrc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mrrc_pkg::*;

   logic               in_valid_ff;
   mrrc_item_type      in_item_ff;
   mrrc_item_type      in_item_in;
   logic               out_valid_ff;
   mrrc_result_type    out_result_ff;
   mrrc_result_type    core_result;
   mrrc_cfg_type       cfg_ff;
   logic [SPEED_W-1:0] pot_goal;
   logic               advance;

   mrrc_pot_scale u_pot_scale (
      .pot_level (req_pot_level),
      .pot_goal  (pot_goal)
   );

   always_comb begin
      in_item_in.forward_pressed  = req_forward_pressed;
      in_item_in.backward_pressed = req_backward_pressed;
      in_item_in.halt_pressed     = req_halt_pressed;
      in_item_in.pot_goal         = pot_goal;
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   mrrc_motion_core u_motion_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step   <= RAMP_STEP_RESET;
         cfg_ff.ramp_period <= RAMP_PERIOD_RESET;
         cfg_ff.stop_dwell  <= STOP_DWELL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RAMP_STEP: begin
               cfg_ff.ramp_step <= csr_data[ACCEL_W-1:0];
            end
            CSR_RAMP_PERIOD: begin
               cfg_ff.ramp_period <= csr_data[INTERVAL_W-1:0];
            end
            CSR_STOP_DWELL: begin
               cfg_ff.stop_dwell <= csr_data[DWELL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_right_enable = out_result_ff.right_enable;
   assign rsp_left_enable  = out_result_ff.left_enable;
   assign rsp_right_duty   = out_result_ff.right_duty;
   assign rsp_left_duty    = out_result_ff.left_duty;
   assign rsp_led_on       = out_result_ff.led_on;
   assign rsp_motion_state = out_result_ff.motion_state;
   assign rsp_speed_now    = out_result_ff.speed_now;
   assign rsp_speed_goal   = out_result_ff.speed_goal;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for motor_reversal_ramp_controller_unit: drives millisecond ticks
// with random gaps, predicts every result in SystemVerilog and checks it as it arrives.
// Depends on mrrc_pkg and the RTL of the block.
module testbench;
   import mrrc_pkg::*;

   localparam int LONG_HOLD_CYCLES = 60;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_forward_pressed;
   logic                   req_backward_pressed;
   logic                   req_halt_pressed;
   logic [POT_W-1:0]       req_pot_level;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_right_enable;
   logic                   rsp_left_enable;
   logic [SPEED_W-1:0]     rsp_right_duty;
   logic [SPEED_W-1:0]     rsp_left_duty;
   logic                   rsp_led_on;
   logic [STATE_W-1:0]     rsp_motion_state;
   logic [SPEED_W-1:0]     rsp_speed_now;
   logic [SPEED_W-1:0]     rsp_speed_goal;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   motor_reversal_ramp_controller_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_forward_pressed  (req_forward_pressed),
      .req_backward_pressed (req_backward_pressed),
      .req_halt_pressed     (req_halt_pressed),
      .req_pot_level        (req_pot_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_right_enable     (rsp_right_enable),
      .rsp_left_enable      (rsp_left_enable),
      .rsp_right_duty       (rsp_right_duty),
      .rsp_left_duty        (rsp_left_duty),
      .rsp_led_on           (rsp_led_on),
      .rsp_motion_state     (rsp_motion_state),
      .rsp_speed_now        (rsp_speed_now),
      .rsp_speed_goal       (rsp_speed_goal),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #10 clock = ~clock;

   mrrc_cfg_type       motor_cfg = '{RAMP_STEP_RESET, RAMP_PERIOD_RESET, STOP_DWELL_RESET};
   logic [STATE_W-1:0] mot_state      = ST_STOP;
   logic [STATE_W-1:0] req_dir        = ST_STOP;
   logic [SPEED_W-1:0] speed_cur      = '0;
   logic [SPEED_W-1:0] speed_tgt      = '0;
   logic               left_side      = 1'b0;
   logic [TIME_W-1:0]  tick_ms        = '0;
   logic [TIME_W-1:0]  last_ramp_ms   = '0;
   logic [TIME_W-1:0]  brake_start_ms = '0;
   logic [1:0]         bridge_en      = EN_NONE;
   logic [SPEED_W-1:0] duty_right     = '0;
   logic [SPEED_W-1:0] duty_left      = '0;

   mrrc_result_type expected_outputs [$];
   int              mismatch_count = 0;
   int              results_seen   = 0;
   int              burst_left     = 0;
   bit              gaps_enabled   = 1'b1;
   bit              hold_request   = 1'b0;

   task automatic predict_tick(input logic fwd, input logic bwd, input logic halt,
                               input logic [POT_W-1:0] pot);
      logic              led;
      logic [TIME_W-1:0] blink;
      logic [31:0]       scaled;
      logic [8:0]        raised;
      mrrc_result_type   res;
      led = 1'b0;
      if (fwd) req_dir = ST_FWD;
      if (bwd) req_dir = ST_BWD;
      if (halt) req_dir = ST_STOP;
      case (mot_state) inside
         ST_STOP: begin
            speed_tgt = '0;
            speed_cur = '0;
            bridge_en = EN_NONE;
            duty_right = '0;
            duty_left = '0;
            if (req_dir == ST_FWD || req_dir == ST_BWD) begin
               mot_state = req_dir;
               left_side = (req_dir == ST_BWD);
               bridge_en = left_side ? EN_LEFT : EN_RIGHT;
            end
         end
         ST_FWD, ST_BWD: begin
            led = 1'b1;
            if (req_dir != mot_state) begin
               mot_state = ST_STOPPING;
               brake_start_ms = tick_ms;
               speed_tgt = '0;
            end
         end
         default: begin
            blink = tick_ms / BLINK_HALF_MS;
            led = blink[0];
            if (speed_cur == 0 && (tick_ms - brake_start_ms) >= 32'(motor_cfg.stop_dwell)) begin
               if (req_dir == ST_FWD || req_dir == ST_BWD) begin
                  mot_state = req_dir;
                  left_side = (req_dir == ST_BWD);
                  bridge_en = left_side ? EN_LEFT : EN_RIGHT;
               end else begin
                  mot_state = ST_STOP;
               end
            end
         end
      endcase
      if ((tick_ms - last_ramp_ms) >= 32'(motor_cfg.ramp_period)) begin
         last_ramp_ms = tick_ms;
         if (mot_state == ST_FWD || mot_state == ST_BWD) begin
            scaled = 32'(pot) * SPEED_FULL_SCALE / POT_FULL_SCALE;
            speed_tgt = (scaled > 32'd255) ? SPEED_MAX : scaled[SPEED_W-1:0];
         end
         if (speed_cur < speed_tgt) begin
            raised = {1'b0, speed_cur} + {1'b0, motor_cfg.ramp_step};
            speed_cur = (raised > {1'b0, speed_tgt}) ? speed_tgt : raised[SPEED_W-1:0];
         end else if (speed_cur > speed_tgt) begin
            speed_cur = (speed_cur > motor_cfg.ramp_step) ? speed_cur - motor_cfg.ramp_step
                                                          : '0;
         end
         if (mot_state != ST_STOP) begin
            if (left_side) duty_left = speed_cur;
            else duty_right = speed_cur;
         end
      end
      res.right_enable = bridge_en[0];
      res.left_enable  = bridge_en[1];
      res.right_duty   = duty_right;
      res.left_duty    = duty_left;
      res.led_on       = led;
      res.motion_state = mot_state;
      res.speed_now    = speed_cur;
      res.speed_goal   = speed_tgt;
      expected_outputs.push_back(res);
      tick_ms = tick_ms + 1;
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   function automatic string describe(input mrrc_result_type r);
      return $sformatf("state %0d speed %0d goal %0d en %b%b duty %0d/%0d led %b",
                       r.motion_state, r.speed_now, r.speed_goal, r.right_enable,
                       r.left_enable, r.right_duty, r.left_duty, r.led_on);
   endfunction

   always @(posedge clock) begin
      mrrc_result_type got;
      mrrc_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = '{rsp_right_enable, rsp_left_enable, rsp_right_duty, rsp_left_duty,
                 rsp_led_on, rsp_motion_state, rsp_speed_now, rsp_speed_goal};
         if (expected_outputs.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
         end else begin
            want = expected_outputs.pop_front();
            if (got !== want)
               report_mismatch($sformatf("item %0d: got %s, expected %s", results_seen,
                                         describe(got), describe(want)));
         end
         results_seen++;
      end
   end

   // The result side cycles through open, random and periodic stall patterns.
   initial begin
      int stall_cycle;
      int hold_left;
      stall_cycle = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         stall_cycle++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case ((stall_cycle / 128) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= (stall_cycle % 7 != 3);
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   task automatic send_tick(input logic fwd, input logic bwd, input logic halt,
                            input logic [POT_W-1:0] pot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_enabled ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid            <= 1'b1;
      req_forward_pressed  <= fwd;
      req_backward_pressed <= bwd;
      req_halt_pressed     <= halt;
      req_pot_level        <= pot;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_tick(fwd, bwd, halt, pot);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_random_tick(input int press_percent);
      int               roll;
      logic [2:0]       buttons;
      logic [POT_W-1:0] pot;
      buttons = 3'b000;
      if ($urandom_range(0, 99) < press_percent) begin
         roll = $urandom_range(0, 9);
         if (roll < 4) buttons = 3'b100;
         else if (roll < 7) buttons = 3'b010;
         else if (roll < 9) buttons = 3'b001;
         else buttons = 3'($urandom_range(1, 7));
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) pot = '0;
      else if (roll < 20) pot = '1;
      else pot = POT_W'($urandom_range(0, 1023));
      send_tick(buttons[2], buttons[1], buttons[0], pot);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(input logic [ACCEL_W-1:0] accel,
                               input logic [INTERVAL_W-1:0] interval,
                               input logic [DWELL_W-1:0] dwell);
      logic [CSR_DATA_W-1:0]  value [3];
      logic [CSR_INDEX_W-1:0] index [3];
      value[0] = CSR_DATA_W'(accel);
      value[1] = CSR_DATA_W'(interval);
      value[2] = CSR_DATA_W'(dwell);
      index[0] = CSR_RAMP_STEP;
      index[1] = CSR_RAMP_PERIOD;
      index[2] = CSR_STOP_DWELL;
      for (int r = 0; r < 3; r++) begin
         csr_valid <= 1'b1;
         csr_index <= index[r];
         csr_data  <= value[r];
         do @(posedge clock); while (csr_ready !== 1'b1);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      motor_cfg = '{accel, interval, dwell};
   endtask

   task automatic test_power_on_defaults();
      send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b0, 1'b0, 10'd512);
      drain_results();
   endtask

   // An update interval of zero ramps on every tick; a zero dwell reverses at once.
   task automatic test_button_priority();
      write_config(8'd255, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 1'b1, 10'd1023);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
      send_tick(1'b1, 1'b1, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b0, 1'b0, 10'd700);
      send_tick(1'b1, 1'b1, 1'b1, 10'd1023);
      send_tick(1'b0, 1'b1, 1'b0, 10'd1023);
      send_tick(1'b1, 1'b0, 1'b0, 10'd1);
      send_tick(1'b0, 1'b0, 1'b0, 10'd1);
      send_tick(1'b0, 1'b0, 1'b1, 10'd0);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      drain_results();
   endtask

   // A large step clamps at the target going up and undershoots it going down.
   task automatic test_ramp_clamping();
      write_config(8'd200, 16'd1, 16'd2);
      send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b0, 1'b0, 10'd300);
      send_tick(1'b0, 1'b0, 1'b0, 10'd300);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      send_tick(1'b0, 1'b1, 1'b0, 10'd512);
      repeat (3) send_tick(1'b0, 1'b0, 1'b0, 10'd512);
      send_tick(1'b0, 1'b0, 1'b1, 10'd0);
      send_tick(1'b0, 1'b0, 1'b0, 10'd0);
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [ACCEL_W-1:0]    accel;
      logic [INTERVAL_W-1:0] interval;
      logic [DWELL_W-1:0]    dwell;
      for (int p = 0; p < 5; p++) begin
         accel    = (p == 0) ? 8'd1 : (p == 1) ? 8'd255 : ACCEL_W'($urandom_range(1, 255));
         interval = (p == 2) ? 16'd0 : INTERVAL_W'($urandom_range(1, 6));
         dwell    = (p == 3) ? 16'd0 : DWELL_W'($urandom_range(1, 40));
         write_config(accel, interval, dwell);
         repeat (70) send_random_tick(12);
         drain_results();
      end
   endtask

   task automatic test_result_backpressure();
      hold_request = 1'b1;
      gaps_enabled = 1'b0;
      repeat (40) send_random_tick(15);
      gaps_enabled = 1'b1;
      drain_results();
   endtask

   task automatic test_extreme_settings();
      write_config(8'd255, 16'd65535, 16'd65535);
      repeat (40) send_random_tick(20);
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_forward_pressed = 1'b0;
      req_backward_pressed = 1'b0;
      req_halt_pressed = 1'b0;
      req_pot_level = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_power_on_defaults();
      test_button_priority();
      test_ramp_clamping();
      test_random_traffic();
      test_result_backpressure();
      test_extreme_settings();
      if (mismatch_count == 0 && expected_outputs.size() == 0)
         $display("motor_reversal_ramp_controller_unit test passed");
      else
         $display("motor_reversal_ramp_controller_unit test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("motor_reversal_ramp_controller_unit test failed");
      $finish;
   end

endmodule
